// File: rtl/smf_pkg.sv
package smf_pkg;

  localparam logic [15:0] MARKER_WORD   = 16'hBEEF;
  localparam logic [3:0]  LAST_WORD     = 4'd9;
  localparam logic [3:0]  FIRST_TX_WORD = 4'd2;
  localparam int          TELEM_DEPTH   = 7;

  localparam logic [15:0] START_MASK_RST  = 16'h8000;
  localparam logic [14:0] DRIVE_LIMIT_RST = 15'd300;

  typedef enum logic [0:0] {
    CFG_START_MASK  = 1'b0,
    CFG_DRIVE_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    OP_WORD  = 1'b0,
    OP_RESET = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [15:0]        rx_word;
    logic signed [31:0] encoder_position;
    logic signed [31:0] spring_position;
    logic signed [15:0] motor_current;
  } in_item_t;

  typedef struct packed {
    logic               tx_load;
    logic [15:0]        tx_word;
    logic               drive_valid;
    logic signed [15:0] drive_value;
  } out_item_t;

endpackage

// File: rtl/smf_if.sv
interface smf_in_if
  import smf_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smf_out_if
  import smf_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/spi_slave_motor_frame_top.sv
// Word handler of a 16-bit SPI slave motor frame.
// in_ch carries one item per received word (or a protocol reset when
// operation is set); out_ch returns exactly one result item per input item:
// a transmit word to load and/or a clamped drive command, or neither.
// The cfg_ port writes start_mask (index 0) and drive_limit (index 1); write
// only while no item is in flight.
// The result is registered and is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes each result; the
// frame state is updated in the accept cycle, and the result register is the only stage.
// in_ch.ready is high whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds the result and
// back-pressures the source after one item.
// Reset (rst_n low, synchronous): result register empty, word counter 0,
// restart flag set, telemetry and command cleared, registers at defaults.
module spi_slave_motor_frame_top
  import smf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  smf_in_if.sink          in_ch,
  smf_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [15:0]     cfg_wdata
);

  logic [15:0] start_mask_r;
  logic [14:0] drive_limit_r;

  logic [3:0]  word_count_r, word_count_nxt;
  logic        restart_r, restart_nxt;
  logic [15:0] command_r, command_nxt;
  logic [15:0] telem_r [TELEM_DEPTH];
  logic [31:0] prev_pos_r, prev_pos_nxt;
  logic        telem_we;

  logic        out_valid_r;
  out_item_t   out_data_r, out_nxt;

  logic        accept;
  logic [2:0]  telem_idx;
  logic signed [16:0] cmd_s, lim_s;
  logic signed [15:0] cmd_clamped;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign telem_idx = 3'(word_count_r - FIRST_TX_WORD);
  assign cmd_s     = 17'(signed'(command_r));
  assign lim_s     = signed'({2'b00, drive_limit_r});

  always_comb begin
    if (cmd_s > lim_s) begin
      cmd_clamped = 16'(lim_s);
    end else if (cmd_s < -lim_s) begin
      cmd_clamped = 16'(-lim_s);
    end else begin
      cmd_clamped = 16'(cmd_s);
    end
  end

  always_comb begin
    word_count_nxt = word_count_r;
    restart_nxt    = restart_r;
    command_nxt    = command_r;
    prev_pos_nxt   = prev_pos_r;
    telem_we       = 1'b0;
    out_nxt        = '0;
    if (in_ch.data.operation == OP_RESET) begin
      word_count_nxt = '0;
      prev_pos_nxt   = in_ch.data.encoder_position;
    end else begin
      if ((in_ch.data.rx_word & start_mask_r) != '0 && !restart_r) begin
        word_count_nxt  = '0;
        restart_nxt     = 1'b1;
        out_nxt.tx_load = 1'b1;
        out_nxt.tx_word = MARKER_WORD;
      end else begin
        restart_nxt = 1'b0;
        if (word_count_r == 4'd1) begin
          command_nxt = in_ch.data.rx_word;
        end else if (word_count_r >= FIRST_TX_WORD && word_count_r < LAST_WORD) begin
          out_nxt.tx_load = 1'b1;
          out_nxt.tx_word = telem_r[telem_idx];
        end else if (word_count_r == LAST_WORD) begin
          prev_pos_nxt        = in_ch.data.encoder_position;
          telem_we            = 1'b1;
          out_nxt.tx_load     = 1'b1;
          out_nxt.tx_word     = MARKER_WORD;
          command_nxt         = cmd_clamped;
          out_nxt.drive_valid = 1'b1;
          out_nxt.drive_value = cmd_clamped;
        end
      end
      if (word_count_nxt <= LAST_WORD) begin
        word_count_nxt = word_count_nxt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mask_r  <= START_MASK_RST;
      drive_limit_r <= DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_MASK:  start_mask_r  <= cfg_wdata;
        CFG_DRIVE_LIMIT: drive_limit_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= '0;
      restart_r    <= 1'b1;
      command_r    <= '0;
      prev_pos_r   <= '0;
      for (int i = 0; i < TELEM_DEPTH; i++) begin
        telem_r[i] <= '0;
      end
    end else if (accept) begin
      word_count_r <= word_count_nxt;
      restart_r    <= restart_nxt;
      command_r    <= command_nxt;
      prev_pos_r   <= prev_pos_nxt;
      if (telem_we) begin
        telem_r[0] <= in_ch.data.encoder_position[15:0];
        telem_r[1] <= in_ch.data.encoder_position[31:16];
        telem_r[2] <= 16'(in_ch.data.encoder_position - prev_pos_r);
        telem_r[3] <= in_ch.data.motor_current;
        telem_r[4] <= in_ch.data.spring_position[15:0];
        telem_r[5] <= in_ch.data.spring_position[31:16];
        telem_r[6] <= MARKER_WORD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

// File: verif/spi_slave_motor_frame_top_test.sv
module spi_slave_motor_frame_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import smf_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_wdata;

  smf_in_if in_ch();
  smf_out_if out_ch();

  spi_slave_motor_frame_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // frame state mirror
  logic [15:0] reg_mask = START_MASK_RST;
  logic [14:0] reg_limit = DRIVE_LIMIT_RST;
  logic [3:0] word_num = '0;
  logic restart_seen = 1'b1;
  logic [15:0] drive_cmd = '0;
  logic [15:0] telemetry [TELEM_DEPTH] = '{default: '0};
  logic [31:0] last_pos = '0;

  in_item_t word_queue [$];
  out_item_t pending_replies [$];
  out_item_t want;

  int src_gap_pct;
  int snk_gap_pct;
  logic hold_off;
  logic in_took;
  int quiet_cycles;
  int unsigned stim_count;
  int unsigned words_in;
  int unsigned replies_in;
  int unsigned loads_seen;
  int unsigned drives_seen;
  int unsigned failures;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic out_item_t advance_frame(in_item_t it);
    out_item_t r;
    logic signed [16:0] cmd;
    logic signed [16:0] lim;
    logic [31:0] vel;
    r = '0;
    if (op_t'(it.operation) == OP_RESET) begin
      word_num = '0;
      last_pos = it.encoder_position;
    end else begin
      if ((it.rx_word & reg_mask) != 16'h0000 && !restart_seen) begin
        word_num = '0;
        restart_seen = 1'b1;
        r.tx_load = 1'b1;
        r.tx_word = MARKER_WORD;
      end else begin
        restart_seen = 1'b0;
        if (word_num == 4'd1) begin
          drive_cmd = it.rx_word;
        end else if (word_num >= FIRST_TX_WORD && word_num < LAST_WORD) begin
          r.tx_load = 1'b1;
          r.tx_word = telemetry[3'(word_num - FIRST_TX_WORD)];
        end else if (word_num == LAST_WORD) begin
          vel = it.encoder_position - last_pos;
          last_pos = it.encoder_position;
          telemetry[0] = it.encoder_position[15:0];
          telemetry[1] = it.encoder_position[31:16];
          telemetry[2] = vel[15:0];
          telemetry[3] = it.motor_current;
          telemetry[4] = it.spring_position[15:0];
          telemetry[5] = it.spring_position[31:16];
          telemetry[6] = MARKER_WORD;
          r.tx_load = 1'b1;
          r.tx_word = MARKER_WORD;
          cmd = {drive_cmd[15], drive_cmd};
          lim = {2'b00, reg_limit};
          if (cmd > lim) cmd = lim;
          if (cmd < -lim) cmd = -lim;
          drive_cmd = cmd[15:0];
          r.drive_valid = 1'b1;
          r.drive_value = drive_cmd;
        end
      end
      if (word_num <= LAST_WORD) word_num = word_num + 4'd1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      failures++;
    end
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        in_ch.data <= word_queue.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_gap_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        replies_in++;
        if (out_ch.data.tx_load) loads_seen++;
        if (out_ch.data.drive_valid) drives_seen++;
        if (pending_replies.size() == 0) begin
          $error("result item with nothing outstanding: %h", out_ch.data);
          failures++;
        end else begin
          want = pending_replies.pop_front();
          check_field("tx_load", 16'(want.tx_load), 16'(out_ch.data.tx_load));
          check_field("tx_word", want.tx_word, out_ch.data.tx_word);
          check_field("drive_valid", 16'(want.drive_valid), 16'(out_ch.data.drive_valid));
          check_field("drive_value", want.drive_value, out_ch.data.drive_value);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        words_in++;
        pending_replies.push_back(advance_frame(in_ch.data));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("spi_slave_motor_frame_top verification failed");
      $finish;
    end
  end

  task automatic queue_word(logic [15:0] rx, logic [31:0] enc, logic [31:0] spr,
                            logic [15:0] cur);
    in_item_t it;
    it.operation = OP_WORD;
    it.rx_word = rx;
    it.encoder_position = enc;
    it.spring_position = spr;
    it.motor_current = cur;
    word_queue.push_back(it);
    stim_count++;
  endtask

  task automatic queue_reset(logic [31:0] enc);
    in_item_t it;
    it.operation = OP_RESET;
    it.rx_word = 16'($urandom);
    it.encoder_position = enc;
    it.spring_position = $urandom;
    it.motor_current = 16'($urandom);
    word_queue.push_back(it);
    stim_count++;
  endtask

  task automatic queue_rand_word(logic [15:0] rx);
    queue_word(rx, $urandom, $urandom, 16'($urandom));
  endtask

  function automatic logic [15:0] clean_word();
    return 16'($urandom) & ~reg_mask;
  endfunction

  function automatic logic [15:0] pick_command();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h8001;
      3: return 16'hFFFF;
      4: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed frames, some truncated, the rest noise
  task automatic queue_frame();
    int kind;
    int len;
    logic [15:0] rx;
    kind = $urandom_range(99);
    if (kind < 60) begin
      rx = 16'($urandom);
      if ((rx & reg_mask) == 16'h0000) rx = rx | reg_mask;
      queue_rand_word(rx);
      queue_rand_word(pick_command());
      len = 8 + $urandom_range(3);
      if ($urandom_range(9) == 0) len = $urandom_range(7);
      repeat (len) queue_rand_word(clean_word());
    end else if (kind < 75) begin
      queue_reset($urandom);
      queue_rand_word(clean_word());
      queue_rand_word(pick_command() & ~reg_mask);
      repeat (8) queue_rand_word(clean_word());
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(9) == 0) queue_reset($urandom);
        else queue_rand_word(16'($urandom));
      end
    end
  endtask

  task automatic fill_words(int unsigned n);
    int unsigned target;
    target = stim_count + n;
    while (stim_count < target) queue_frame();
  endtask

  task automatic settle();
    while (word_queue.size() != 0 || pending_replies.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_START_MASK) reg_mask = v;
    else reg_limit = v[14:0];
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_START_MASK;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_off = 1'b0;
    in_took = 1'b0;
    quiet_cycles = 0;
    stim_count = 0;
    words_in = 0;
    replies_in = 0;
    loads_seen = 0;
    drives_seen = 0;
    failures = 0;
    src_gap_pct = 16;
    snk_gap_pct = 65;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // start bits right after reset are taken as the header
    queue_word(16'hFFFF, 32'h0, 32'h0, 16'h0);
    queue_word(16'h7FFF, 32'h0, 32'h0, 16'h0);
    for (int i = 0; i < 7; i++) queue_word(i[0] ? 16'h7FFF : 16'h0000, 32'h0, 32'h0, 16'h0);
    queue_word(16'h0000, 32'h7FFFFFFF, 32'h80000000, 16'h8000);
    queue_word(16'h1234, 32'h0, 32'h0, 16'h0);
    queue_word(16'h8000, 32'h0, 32'h0, 16'h0);
    queue_word(16'h8000, 32'h0, 32'h0, 16'h0);
    for (int i = 0; i < 7; i++) queue_word(16'h7FFF, $urandom, $urandom, 16'($urandom));
    queue_word(16'h0000, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF);
    queue_reset(32'hFFFFFFFF);
    queue_word(16'hFFFF, 32'h0, 32'h0, 16'h0);
    queue_word(16'hFFFF, 32'h0, 32'h0, 16'h0);
    queue_reset(32'h0);
    settle();

    write_reg(CFG_START_MASK, 16'hFFFF);
    write_reg(CFG_DRIVE_LIMIT, 16'h0000);
    fill_words(320);
    settle();

    src_gap_pct = 65;
    snk_gap_pct = 16;
    write_reg(CFG_START_MASK, 16'h0001);
    write_reg(CFG_DRIVE_LIMIT, 16'hFFFF);
    fill_words(300);
    settle();

    src_gap_pct = 0;
    snk_gap_pct = 0;
    write_reg(CFG_START_MASK, 16'($urandom));
    write_reg(CFG_DRIVE_LIMIT, 16'($urandom));
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    fill_words(60);
    settle();
    fill_words(250);
    settle();

    // no start bits at all: frames only realign on protocol reset
    write_reg(CFG_START_MASK, 16'h0000);
    write_reg(CFG_DRIVE_LIMIT, 16'h8000 | 16'($urandom_range(16'h7FFF)));
    fill_words(220);
    settle();

    $display("run: %0d items in, %0d results checked, %0d transmit loads, %0d drive commands",
             words_in, replies_in, loads_seen, drives_seen);
    $display("run: start masks 8000/FFFF/0001/random/0000, drive limits 300/0/max/random");
    if (failures == 0) begin
      $display("spi_slave_motor_frame_top verification clean");
    end else begin
      $display("spi_slave_motor_frame_top verification failed");
    end
    $finish;
  end

endmodule

// File: spi_slave_motor_frame_top.f
rtl/smf_pkg.sv
rtl/smf_if.sv
rtl/spi_slave_motor_frame_top.sv
verif/spi_slave_motor_frame_top_test.sv
